>>> hw/rtl/packet_delay_hold_queue_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef PACKET_DELAY_HOLD_QUEUE_MACROS_SVH
`define PACKET_DELAY_HOLD_QUEUE_MACROS_SVH

// property holds in the same cycle
`define PDHQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define PDHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pdhq_pkg.sv
package pdhq_pkg;

	localparam int DEPTH          = 32;
	localparam int IDX_W          = $clog2(DEPTH);
	localparam int CNT_W          = $clog2(DEPTH + 1);
	localparam int HOLD_LIMIT_DEF = 31;
	localparam int CMD_FIFO_DEPTH = 2;
	localparam int OUT_FIFO_DEPTH = 2;

	localparam logic [15:0] LAG_RESET    = 16'd200;
	localparam logic [13:0] CHANCE_RESET = 14'd10000;

	typedef enum logic [1:0] {
		REG_LAG      = 2'd0,
		REG_INB_EN   = 2'd1,
		REG_OUTB_EN  = 2'd2,
		REG_CHANCE   = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ACT_ARRIVE = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_FLUSH  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_PASS    = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_FLUSH   = 2'd2,
		KIND_STATUS  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PASS,
		OP_HOLD,
		OP_TICK,
		OP_FLUSH
	} op_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_PASS,
		B_HOLD_WR,
		B_TICK_RD,
		B_TICK_EV,
		B_TICK_CHK,
		B_STATUS,
		B_FL_RD,
		B_FL_EM
	} back_state_t;

	typedef enum logic [1:0] {
		FLM_ACTION,
		FLM_ARRIVE,
		FLM_TICK
	} flush_mode_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] handle;
		logic [31:0] stamp;
	} cmd_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [31:0] stamp;
	} hold_entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] handle;
		logic        last;
		logic        sched;
		logic [15:0] wait_ms;
	} result_t;

endpackage

>>> hw/rtl/packet_delay_hold_queue.sv
// packet delay hold queue
// input side is a queue: drive action and payload, raise push while full is low;
// the item is taken at that edge. action 0 is a packet arrival, 1 a tick at now_ms,
// 2 a flush, 3 is ignored.
// result side is a queue: while empty is low the oldest result item is on kind,
// out_handle, last, schedule_valid and wait_ms; pop takes it. last marks the final
// item of one input item.
// config: cfg_wr_en writes cfg_data into register cfg_index
// (0 lag_ms, 1 inbound_enable, 2 outbound_enable, 3 chance_hundredths).
// a two-entry command queue sits between the classifier and the sequencer, and a
// two-entry result queue sits behind the sequencer, so each side stalls alone.
// sequencing: a flush reads and emits each held packet in turn, and a tick reads each
// held packet and releases or keeps it; when the kept packets exceed the hold limit the
// tick then flushes them, as an arrival into a full store first flushes the store; the
// held store has a single read and a single write port and each entry takes a read
// state and then a release, keep or flush state.
// when pop stays low the result queue fills and the sequencer waits, then the
// command queue fills and full rises.
// reset empties both queues and the store and loads lag 200, both directions
// enabled and chance 10000.
module packet_delay_hold_queue #(
	parameter int HOLD_LIMIT = pdhq_pkg::HOLD_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [15:0] packet_handle,
	input  logic        outbound,
	input  logic [31:0] captured_ms,
	input  logic [13:0] random_draw,
	input  logic [31:0] now_ms,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [15:0] out_handle,
	output logic        last,
	output logic        schedule_valid,
	output logic [15:0] wait_ms
);

	pdhq_pkg::cmd_t    front_cmd;
	pdhq_pkg::cmd_t    back_cmd;
	pdhq_pkg::result_t back_res;
	pdhq_pkg::result_t head_res;
	logic [15:0]       lag;
	logic              cmd_empty;
	logic              cmd_pop;
	logic              res_push;
	logic              res_full;

	pdhq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.packet_handle (packet_handle),
		.outbound      (outbound),
		.captured_ms   (captured_ms),
		.random_draw   (random_draw),
		.now_ms        (now_ms),
		.cmd           (front_cmd),
		.lag_ms        (lag)
	);

	pdhq_fifo #(
		.T     (pdhq_pkg::cmd_t),
		.DEPTH (pdhq_pkg::CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (back_cmd),
		.empty  (cmd_empty)
	);

	pdhq_back #(
		.HOLD_LIMIT (HOLD_LIMIT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.lag_ms    (lag),
		.cmd_in    (back_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_push  (res_push),
		.out_res   (back_res),
		.out_full  (res_full)
	);

	pdhq_fifo #(
		.T     (pdhq_pkg::result_t),
		.DEPTH (pdhq_pkg::OUT_FIFO_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (head_res),
		.empty  (empty)
	);

	assign kind           = head_res.kind;
	assign out_handle     = head_res.handle;
	assign last           = head_res.last;
	assign schedule_valid = head_res.sched;
	assign wait_ms        = head_res.wait_ms;

endmodule

>>> hw/rtl/pdhq_fifo.sv
module pdhq_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   used_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (used_q == CW'(DEPTH));
	assign empty   = (used_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				used_q <= used_q + 1'b1;
			end else if (do_pop && !do_push) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> hw/rtl/pdhq_front.sv
module pdhq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic [1:0]     action,
	input  logic [15:0]    packet_handle,
	input  logic           outbound,
	input  logic [31:0]    captured_ms,
	input  logic [13:0]    random_draw,
	input  logic [31:0]    now_ms,
	output pdhq_pkg::cmd_t cmd,
	output logic [15:0]    lag_ms
);

	logic [15:0] lag_q;
	logic        inb_en_q;
	logic        outb_en_q;
	logic [13:0] chance_q;
	logic        dir_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q     <= pdhq_pkg::LAG_RESET;
			inb_en_q  <= 1'b1;
			outb_en_q <= 1'b1;
			chance_q  <= pdhq_pkg::CHANCE_RESET;
		end else if (cfg_wr_en) begin
			case (pdhq_pkg::reg_index_t'(cfg_index))
				pdhq_pkg::REG_LAG:     lag_q     <= cfg_data;
				pdhq_pkg::REG_INB_EN:  inb_en_q  <= cfg_data[0];
				pdhq_pkg::REG_OUTB_EN: outb_en_q <= cfg_data[0];
				pdhq_pkg::REG_CHANCE:  chance_q  <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	assign lag_ms = lag_q;
	assign dir_en = outbound ? outb_en_q : inb_en_q;

	always_comb begin
		cmd.handle = packet_handle;
		cmd.stamp  = captured_ms;
		case (pdhq_pkg::action_t'(action))
			pdhq_pkg::ACT_ARRIVE: begin
				cmd.op = (dir_en && (random_draw < chance_q)) ? pdhq_pkg::OP_HOLD
					: pdhq_pkg::OP_PASS;
			end
			pdhq_pkg::ACT_TICK: begin
				cmd.op    = pdhq_pkg::OP_TICK;
				cmd.stamp = now_ms;
			end
			pdhq_pkg::ACT_FLUSH: cmd.op = pdhq_pkg::OP_FLUSH;
			default:             cmd.op = pdhq_pkg::OP_NONE;
		endcase
	end

endmodule

>>> hw/rtl/pdhq_back.sv
`include "packet_delay_hold_queue_macros.svh"

module pdhq_back #(
	parameter int HOLD_LIMIT = pdhq_pkg::HOLD_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       lag_ms,
	input  pdhq_pkg::cmd_t    cmd_in,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output logic              out_push,
	output pdhq_pkg::result_t out_res,
	input  logic              out_full
);

	localparam int IW = pdhq_pkg::IDX_W;
	localparam int CW = pdhq_pkg::CNT_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(pdhq_pkg::DEPTH);
	localparam logic [6:0]    LIMIT    = 7'(HOLD_LIMIT);

	pdhq_pkg::back_state_t state_q, state_d;
	pdhq_pkg::flush_mode_t flmode_q;
	pdhq_pkg::cmd_t        cmd_q;
	pdhq_pkg::hold_entry_t mem_q [pdhq_pkg::DEPTH];
	pdhq_pkg::hold_entry_t rd_data_q;
	pdhq_pkg::hold_entry_t mem_wdata;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] keep_q;
	logic [31:0]   nl_q;
	logic [15:0]   best_q;
	logic          have_q;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic [31:0]   past;
	logic [31:0]   rem;
	logic [15:0]   rem_sat;
	logic          overdue;
	logic          at_end;

	// nl_q holds now minus lag, so past is now minus deadline
	assign past    = nl_q - rd_data_q.stamp;
	assign rem     = rd_data_q.stamp - nl_q;
	assign rem_sat = (rem[31:16] != '0) ? 16'hFFFF : rem[15:0];
	assign overdue = (past != '0) && !past[31];
	assign at_end  = ((idx_q + 1'b1) == count_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdhq_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					case (cmd_in.op)
						pdhq_pkg::OP_PASS: state_d = pdhq_pkg::B_PASS;
						pdhq_pkg::OP_HOLD: begin
							state_d = (count_q == FULL_CNT) ? pdhq_pkg::B_FL_RD
								: pdhq_pkg::B_HOLD_WR;
						end
						pdhq_pkg::OP_TICK: begin
							state_d = (count_q == '0) ? pdhq_pkg::B_TICK_CHK
								: pdhq_pkg::B_TICK_RD;
						end
						pdhq_pkg::OP_FLUSH: begin
							state_d = (count_q == '0) ? pdhq_pkg::B_IDLE : pdhq_pkg::B_FL_RD;
						end
						default: state_d = pdhq_pkg::B_IDLE;
					endcase
				end
			end
			pdhq_pkg::B_PASS: begin
				if (!out_full) state_d = pdhq_pkg::B_IDLE;
			end
			pdhq_pkg::B_HOLD_WR: state_d = pdhq_pkg::B_IDLE;
			pdhq_pkg::B_TICK_RD: state_d = pdhq_pkg::B_TICK_EV;
			pdhq_pkg::B_TICK_EV: begin
				if (!(overdue && out_full)) begin
					state_d = at_end ? pdhq_pkg::B_TICK_CHK : pdhq_pkg::B_TICK_RD;
				end
			end
			pdhq_pkg::B_TICK_CHK: begin
				state_d = ({1'b0, keep_q} > LIMIT) ? pdhq_pkg::B_FL_RD : pdhq_pkg::B_STATUS;
			end
			pdhq_pkg::B_STATUS: begin
				if (!out_full) state_d = pdhq_pkg::B_IDLE;
			end
			pdhq_pkg::B_FL_RD: state_d = pdhq_pkg::B_FL_EM;
			pdhq_pkg::B_FL_EM: begin
				if (!out_full) begin
					if (!at_end) begin
						state_d = pdhq_pkg::B_FL_RD;
					end else begin
						case (flmode_q)
							pdhq_pkg::FLM_ARRIVE: state_d = pdhq_pkg::B_HOLD_WR;
							pdhq_pkg::FLM_TICK:   state_d = pdhq_pkg::B_STATUS;
							default:              state_d = pdhq_pkg::B_IDLE;
						endcase
					end
				end
			end
			default: state_d = pdhq_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		out_push  = 1'b0;
		out_res   = '0;
		mem_we    = 1'b0;
		mem_waddr = count_q[IW-1:0];
		mem_wdata = rd_data_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[IW-1:0];
		case (state_q)
			pdhq_pkg::B_IDLE: cmd_pop = !cmd_empty;
			pdhq_pkg::B_PASS: begin
				out_push       = !out_full;
				out_res.kind   = pdhq_pkg::KIND_PASS;
				out_res.handle = cmd_q.handle;
				out_res.last   = 1'b1;
			end
			pdhq_pkg::B_HOLD_WR: begin
				mem_we           = 1'b1;
				mem_wdata.handle = cmd_q.handle;
				mem_wdata.stamp  = cmd_q.stamp;
			end
			pdhq_pkg::B_TICK_RD: mem_re = 1'b1;
			pdhq_pkg::B_TICK_EV: begin
				if (overdue) begin
					out_push       = !out_full;
					out_res.kind   = pdhq_pkg::KIND_RELEASE;
					out_res.handle = rd_data_q.handle;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = keep_q[IW-1:0];
				end
			end
			pdhq_pkg::B_STATUS: begin
				out_push        = !out_full;
				out_res.kind    = pdhq_pkg::KIND_STATUS;
				out_res.last    = 1'b1;
				out_res.sched   = have_q;
				out_res.wait_ms = have_q ? best_q : '0;
			end
			pdhq_pkg::B_FL_RD: mem_re = 1'b1;
			pdhq_pkg::B_FL_EM: begin
				out_push       = !out_full;
				out_res.kind   = pdhq_pkg::KIND_FLUSH;
				out_res.handle = rd_data_q.handle;
				out_res.last   = at_end && (flmode_q != pdhq_pkg::FLM_TICK);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pdhq_pkg::B_IDLE;
			flmode_q <= pdhq_pkg::FLM_ACTION;
			count_q  <= '0;
			idx_q    <= '0;
			keep_q   <= '0;
			have_q   <= 1'b0;
			best_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pdhq_pkg::B_IDLE: begin
					idx_q    <= '0;
					keep_q   <= '0;
					have_q   <= 1'b0;
					best_q   <= '0;
					flmode_q <= (cmd_in.op == pdhq_pkg::OP_HOLD) ? pdhq_pkg::FLM_ARRIVE
						: pdhq_pkg::FLM_ACTION;
				end
				pdhq_pkg::B_HOLD_WR: count_q <= count_q + 1'b1;
				pdhq_pkg::B_TICK_EV: begin
					if (!overdue) begin
						keep_q <= keep_q + 1'b1;
						have_q <= 1'b1;
						if (!have_q || (rem_sat < best_q)) best_q <= rem_sat;
					end
					if (!(overdue && out_full)) idx_q <= idx_q + 1'b1;
				end
				pdhq_pkg::B_TICK_CHK: begin
					count_q  <= keep_q;
					idx_q    <= '0;
					flmode_q <= pdhq_pkg::FLM_TICK;
					if ({1'b0, keep_q} > LIMIT) begin
						have_q <= 1'b0;
						best_q <= '0;
					end
				end
				pdhq_pkg::B_FL_EM: begin
					if (!out_full) begin
						idx_q <= idx_q + 1'b1;
						if (at_end) count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pdhq_pkg::B_IDLE && !cmd_empty) begin
			cmd_q <= cmd_in;
			nl_q  <= cmd_in.stamp - {16'b0, lag_ms};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rd_data_q <= mem_q[mem_raddr];
	end

	`PDHQ_ASSERT(a_count_range, count_q <= FULL_CNT, "held count above store depth")
	`PDHQ_ASSERT(a_hold_room, (state_q != pdhq_pkg::B_HOLD_WR) || (count_q < FULL_CNT),
		"hold write into full store")
	`PDHQ_ASSERT(a_keep_le_idx, (state_q != pdhq_pkg::B_TICK_EV) || (keep_q <= idx_q),
		"compaction write ahead of read")
	`PDHQ_ASSERT(a_push_room, !out_push || !out_full, "result push into full queue")
	`PDHQ_ASSERT_NEXT(a_status_done, (state_q == pdhq_pkg::B_STATUS) && !out_full,
		state_q == pdhq_pkg::B_IDLE, "tick status did not end the item")

endmodule

>>> dv/packet_delay_hold_queue_test.sv
module packet_delay_hold_queue_test;

	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		pdhq_pkg::action_t act;
		logic [15:0]       handle;
		logic              dir_out;
		logic [31:0]       cap_ms;
		logic [13:0]       draw;
		logic [31:0]       tick_ms;
	} pkt_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  action = '0;
	logic [15:0] packet_handle = '0;
	logic        outbound = 1'b0;
	logic [31:0] captured_ms = '0;
	logic [13:0] random_draw = '0;
	logic [31:0] now_ms = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [15:0] out_handle;
	logic        last;
	logic        schedule_valid;
	logic [15:0] wait_ms;

	packet_delay_hold_queue u_top (.*);

	always #4 clk = ~clk;

	// model of the hold store and its settings
	logic [15:0] held_tag [$];
	logic [31:0] held_stamp [$];
	logic [15:0] lag_cfg = pdhq_pkg::LAG_RESET;
	logic        inb_cfg = 1'b1;
	logic        outb_cfg = 1'b1;
	logic [13:0] chance_cfg = pdhq_pkg::CHANCE_RESET;

	pdhq_pkg::result_t due_q[$];
	pkt_cmd_t          cmd_q[$];
	logic [31:0]       clock_ms;
	logic              steady = 1'b0;
	int                slips = 0;

	function automatic void add_result(pdhq_pkg::kind_t k, logic [15:0] h, logic s,
			logic [15:0] w);
		pdhq_pkg::result_t r;
		r.kind = k;
		r.handle = h;
		r.last = 1'b0;
		r.sched = s;
		r.wait_ms = w;
		due_q.push_back(r);
	endfunction

	function automatic void flush_held();
		foreach (held_tag[i])
			add_result(pdhq_pkg::KIND_FLUSH, held_tag[i], 1'b0, 16'd0);
		held_tag.delete();
		held_stamp.delete();
	endfunction

	function automatic void predict_results(pkt_cmd_t c);
		int          base;
		logic        en;
		logic        have;
		logic [31:0] deadline;
		logic [31:0] past;
		logic [31:0] rem;
		logic [31:0] best;
		logic [15:0] kept_tag [$];
		logic [31:0] kept_stamp [$];
		base = due_q.size();
		have = 1'b0;
		best = '0;
		case (c.act)
			pdhq_pkg::ACT_ARRIVE: begin
				en = c.dir_out ? outb_cfg : inb_cfg;
				if (en && c.draw < chance_cfg) begin
					if (held_tag.size() >= pdhq_pkg::DEPTH)
						flush_held();
					held_tag.push_back(c.handle);
					held_stamp.push_back(c.cap_ms);
				end else begin
					add_result(pdhq_pkg::KIND_PASS, c.handle, 1'b0, 16'd0);
				end
			end
			pdhq_pkg::ACT_TICK: begin
				foreach (held_tag[i]) begin
					deadline = held_stamp[i] + lag_cfg;
					past = c.tick_ms - deadline;
					// overdue when strictly past the deadline in signed time
					if (past != 0 && !past[31]) begin
						add_result(pdhq_pkg::KIND_RELEASE, held_tag[i], 1'b0, 16'd0);
					end else begin
						rem = deadline - c.tick_ms;
						if (rem > 32'hFFFF)
							rem = 32'hFFFF;
						if (!have || rem < best)
							best = rem;
						have = 1'b1;
						kept_tag.push_back(held_tag[i]);
						kept_stamp.push_back(held_stamp[i]);
					end
				end
				held_tag = kept_tag;
				held_stamp = kept_stamp;
				if (held_tag.size() > pdhq_pkg::HOLD_LIMIT_DEF) begin
					flush_held();
					have = 1'b0;
					best = '0;
				end
				add_result(pdhq_pkg::KIND_STATUS, 16'd0, have, best[15:0]);
			end
			pdhq_pkg::ACT_FLUSH: flush_held();
			default: ;
		endcase
		if (due_q.size() > base)
			due_q[due_q.size() - 1].last = 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 55)
			return 0;
		if (r < 85)
			return int'($urandom_range(1, 3));
		if (r < 97)
			return int'($urandom_range(4, 10));
		return int'($urandom_range(20, 40));
	endfunction

	// stimulus builders
	function automatic void queue_cmd(pdhq_pkg::action_t a, logic [15:0] h, logic d,
			logic [31:0] cap, logic [13:0] draw, logic [31:0] tick);
		pkt_cmd_t c;
		c.act = a;
		c.handle = h;
		c.dir_out = d;
		c.cap_ms = cap;
		c.draw = draw;
		c.tick_ms = tick;
		cmd_q.push_back(c);
	endfunction

	function automatic void queue_plain(pdhq_pkg::action_t a);
		queue_cmd(a, 16'($urandom), 1'($urandom), $urandom, 14'($urandom), $urandom);
	endfunction

	function automatic void queue_timed_tick(logic [31:0] tick);
		queue_cmd(pdhq_pkg::ACT_TICK, 16'($urandom), 1'($urandom), $urandom,
			14'($urandom), tick);
	endfunction

	function automatic void queue_held_arrival();
		logic        d;
		logic [13:0] draw;
		if (inb_cfg && !outb_cfg)
			d = 1'b0;
		else if (outb_cfg && !inb_cfg)
			d = 1'b1;
		else
			d = 1'($urandom_range(0, 1));
		if (chance_cfg == 0)
			draw = 14'($urandom_range(0, 16383));
		else
			draw = 14'($urandom_range(0, chance_cfg - 1));
		queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'($urandom_range(0, 65535)), d,
			clock_ms + $urandom_range(0, 60), draw, $urandom);
	endfunction

	function automatic void queue_tick(logic advance);
		if (advance)
			clock_ms += $urandom_range(0, 2 * lag_cfg + 100);
		queue_cmd(pdhq_pkg::ACT_TICK, 16'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1)), $urandom, 14'($urandom_range(0, 16383)), clock_ms);
	endfunction

	function automatic void queue_fill(int n);
		repeat (n)
			queue_held_arrival();
	endfunction

	function automatic void queue_random(int budget);
		int pick;
		int n;
		while (budget > 0) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 55) begin
				n = int'($urandom_range(1, 8));
				repeat (n) begin
					if ($urandom_range(0, 3) != 0)
						queue_held_arrival();
					else
						queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'($urandom_range(0, 65535)),
							1'($urandom_range(0, 1)), clock_ms + $urandom_range(0, 60),
							14'($urandom_range(0, 16383)), $urandom);
				end
				queue_tick(1'b1);
				budget -= n + 1;
			end else if (pick < 70) begin
				// queue 29 to 34 arrivals to fill the store near, up to or past its depth
				n = int'($urandom_range(29, 34));
				queue_fill(n);
				if ($urandom_range(0, 2) != 0)
					queue_tick(1'b0);
				else
					queue_plain(pdhq_pkg::ACT_FLUSH);
				budget -= n + 1;
			end else if (pick < 80) begin
				queue_plain(pdhq_pkg::ACT_FLUSH);
				budget--;
			end else begin
				queue_cmd(pdhq_pkg::action_t'($urandom_range(0, 3)), 16'($urandom),
					1'($urandom), $urandom, 14'($urandom_range(0, 16383)), $urandom);
				budget--;
			end
		end
	endfunction

	task automatic write_reg(pdhq_pkg::reg_index_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			pdhq_pkg::REG_LAG: lag_cfg = val;
			pdhq_pkg::REG_INB_EN: inb_cfg = val[0];
			pdhq_pkg::REG_OUTB_EN: outb_cfg = val[0];
			pdhq_pkg::REG_CHANCE: chance_cfg = val[13:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] lag, logic inb, logic outb, logic [13:0] chance);
		write_reg(pdhq_pkg::REG_LAG, lag);
		write_reg(pdhq_pkg::REG_INB_EN, {15'd0, inb});
		write_reg(pdhq_pkg::REG_OUTB_EN, {15'd0, outb});
		write_reg(pdhq_pkg::REG_CHANCE, {2'd0, chance});
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || push || due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// item driver
	pkt_cmd_t cur_cmd;
	int       send_wait = 0;

	always @(posedge clk) begin
		logic took;
		if (arst_n) begin
			took = push && !full;
			if (took) begin
				predict_results(cur_cmd);
				send_wait = pick_gap();
			end
			if (!push || took) begin
				if (send_wait > 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					action <= cur_cmd.act;
					packet_handle <= cur_cmd.handle;
					outbound <= cur_cmd.dir_out;
					captured_ms <= cur_cmd.cap_ms;
					random_draw <= cur_cmd.draw;
					now_ms <= cur_cmd.tick_ms;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result monitor
	int pop_wait = 0;

	always @(posedge clk) begin
		pdhq_pkg::result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (due_q.size() == 0) begin
					slips++;
					if (slips <= 10)
						$display("unexpected item: kind %0d handle %h last %b sched %b wait %0d",
							kind, out_handle, last, schedule_valid, wait_ms);
				end else begin
					want = due_q.pop_front();
					if (kind !== want.kind || out_handle !== want.handle || last !== want.last ||
							schedule_valid !== want.sched || wait_ms !== want.wait_ms) begin
						slips++;
						if (slips <= 10) begin
							$display("mismatch: want kind %0d handle %h last %b sched %b wait %0d",
								want.kind, want.handle, want.last, want.sched, want.wait_ms);
							$display("          got  kind %0d handle %h last %b sched %b wait %0d",
								kind, out_handle, last, schedule_valid, wait_ms);
						end
					end
				end
				pop_wait = pick_gap();
			end
			if (pop_wait > 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		clock_ms = $urandom;
		// reset settings: lag 200, always hold unless the draw reaches 10000
		queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'h0000, 1'b0, 32'h0000_0000, 14'd0, $urandom);
		queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 14'd9999, $urandom);
		queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'h1234, 1'b0, 32'd5, 14'h3FFF, $urandom);
		queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'hABCD, 1'b1, 32'd7, 14'd10000, $urandom);
		// ticks at each held deadline and then one past it
		queue_timed_tick(32'd199);
		queue_timed_tick(32'd200);
		queue_timed_tick(32'd201);
		// capture far ahead of now saturates the wait
		queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'h0055, 1'b0, 32'd1000000, 14'd5, $urandom);
		queue_timed_tick(32'd0);
		queue_cmd(pdhq_pkg::ACT_ARRIVE, 16'h00AA, 1'b1, 32'd1000010, 14'd77, $urandom);
		queue_plain(pdhq_pkg::ACT_FLUSH);
		queue_plain(pdhq_pkg::ACT_FLUSH);
		queue_plain(pdhq_pkg::ACT_NONE);
		queue_timed_tick(32'hFFFF_FFFF);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		set_config(16'd0, 1'b1, 1'b1, 14'd5000);
		queue_random(80);
		settle();

		set_config(16'hFFFF, 1'b0, 1'b1, 14'd10000);
		clock_ms = 32'hFFFF_F000;
		queue_random(80);
		settle();

		steady = 1'b1;
		set_config(16'd300, 1'b1, 1'b0, 14'd0);
		queue_random(50);
		settle();

		steady = 1'b0;
		set_config(16'd150, 1'b1, 1'b1, 14'h3FFF);
		// over the hold limit after a tick, then an arrival into a full store
		queue_fill(32);
		queue_tick(1'b0);
		queue_fill(33);
		queue_plain(pdhq_pkg::ACT_FLUSH);
		queue_random(60);
		settle();

		set_config(16'd1000, 1'b1, 1'b1, 14'd9000);
		queue_random(55);
		settle();
		queue_random(55);
		settle();

		if (slips == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
